@@ sv/dpta_pkg.sv @@
// ----------------------------------------------------------------------------
// Dynamic payload type allocator package
// Shared constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dpta_pkg;

    localparam int KEY_FIELD_W = 16;
    localparam int TYPE_W      = 7;
    localparam int COUNT_W     = 8;

    localparam logic [COUNT_W-1:0] TYPE_MIN = 8'd96;
    localparam logic [COUNT_W-1:0] TYPE_MAX = 8'd127;

    localparam logic KIND_GET      = 1'b0;
    localparam logic KIND_REGISTER = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NO_CODEC  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DISPATCH,
        OP_FIND,
        OP_CLEAR,
        OP_DRAW,
        OP_BIND,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_find;
        logic need_clear;
        logic hit;
        logic scan_last;
        logic draw_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/dpta_ctrl.sv @@
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences dispatch, table scan, counter draw, bind and result hand-off.
// ----------------------------------------------------------------------------
module dpta_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output dpta_pkg::dp_cmd_t   cmd,
    input  dpta_pkg::dp_status_t stat
);
    import dpta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_CLEAR,
        S_DRAW,
        S_BIND,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (stat.need_find) begin
                    state_next = S_FIND;
                end else if (stat.need_clear) begin
                    state_next = S_CLEAR;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FIND: begin
                // A hit on the last slot wins over falling through to the draw.
                priority if (stat.hit) begin
                    state_next = S_FINISH;
                end else if (stat.scan_last) begin
                    state_next = S_DRAW;
                end
            end
            S_CLEAR: begin
                if (stat.scan_last) begin
                    state_next = S_BIND;
                end
            end
            S_DRAW: begin
                if (stat.draw_done) begin
                    state_next = S_FINISH;
                end
            end
            S_BIND: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        unique case (state_reg)
            S_IDLE:     cmd.op = OP_IDLE;
            S_DISPATCH: cmd.op = OP_DISPATCH;
            S_FIND:     cmd.op = OP_FIND;
            S_CLEAR:    cmd.op = OP_CLEAR;
            S_DRAW:     cmd.op = OP_DRAW;
            S_BIND:     cmd.op = OP_BIND;
            S_FINISH:   cmd.op = OP_FINISH;
            default:    cmd.op = OP_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

@@ sv/dpta_datapath.sv @@
// ----------------------------------------------------------------------------
// Allocator datapath
// Request and result registers, type counter, slot table and output register.
// ----------------------------------------------------------------------------
module dpta_datapath #(
    parameter int KEY_BITS = 16,
    parameter int SLOTS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    input  dpta_pkg::dp_cmd_t    cmd,
    output dpta_pkg::dp_status_t stat
);
    import dpta_pkg::*;

    localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [COUNT_W-1:0] SLOT_END = COUNT_W'(96 + SLOTS);

    // Control state
    logic                share_mode_reg;
    logic [COUNT_W-1:0]  next_type_reg;
    logic [SLOTS-1:0]    used_reg;
    logic [CW-1:0]       scan_cnt_reg;
    logic                rd_vld_reg;
    logic                m_tvalid_reg;

    // Payload state
    logic                req_kind_reg;
    logic [KW-1:0]       req_key_reg;
    logic                req_present_reg;
    logic [TYPE_W-1:0]   req_tnum_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [KW-1:0]       rd_key_reg;
    logic [TYPE_W-1:0]   res_pt_reg;
    status_t             res_status_reg;
    logic [TYPE_W-1:0]   out_pt_reg;
    status_t             out_status_reg;

    logic [KW-1:0]       key_mem [SLOTS];

    logic                s_fire;
    logic                share_present;
    logic                exhausted;
    logic [COUNT_W-1:0]  draw_off;
    logic [IW-1:0]       draw_idx;
    logic                draw_has_slot;
    logic                draw_free;
    logic [COUNT_W-1:0]  tnum_off;
    logic [IW-1:0]       tnum_idx;
    logic                tnum_has_slot;
    logic                scanning;
    logic                issue;
    logic [IW-1:0]       scan_idx;
    logic                hit;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    logic                out_free;
    logic                draw_take;

    assign s_fire        = s_tvalid && s_tready;
    assign share_present = share_mode_reg && req_present_reg;

    assign exhausted     = next_type_reg > TYPE_MAX;
    assign draw_off      = next_type_reg - TYPE_MIN;
    assign draw_idx      = draw_off[IW-1:0];
    assign draw_has_slot = next_type_reg < SLOT_END;
    assign draw_free     = !draw_has_slot || !used_reg[draw_idx];
    assign draw_take     = (cmd.op == OP_DRAW) && !exhausted && draw_free;

    assign tnum_off      = {1'b0, req_tnum_reg} - TYPE_MIN;
    assign tnum_idx      = tnum_off[IW-1:0];
    assign tnum_has_slot = ({1'b0, req_tnum_reg} >= TYPE_MIN)
                           && ({1'b0, req_tnum_reg} < SLOT_END);

    // Table scan: one read issued per cycle, compared the cycle after.
    assign scanning = (cmd.op == OP_FIND) || (cmd.op == OP_CLEAR);
    assign issue    = scanning && (scan_cnt_reg < CW'(SLOTS));
    assign scan_idx = scan_cnt_reg[IW-1:0];
    assign hit      = rd_vld_reg && used_reg[rd_idx_reg] && (rd_key_reg == req_key_reg);

    assign wr_en  = (draw_take && draw_has_slot)
                    || ((cmd.op == OP_BIND) && tnum_has_slot);
    assign wr_idx = (cmd.op == OP_BIND) ? tnum_idx : draw_idx;

    assign out_free = !m_tvalid_reg || m_tready;

    assign stat.need_find  = (req_kind_reg == KIND_GET) && share_present;
    assign stat.need_clear = (req_kind_reg == KIND_REGISTER) && share_present;
    assign stat.hit        = hit;
    assign stat.scan_last  = rd_vld_reg && (rd_idx_reg == IW'(SLOTS - 1));
    assign stat.draw_done  = exhausted || draw_free;
    assign stat.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            share_mode_reg <= 1'b0;
            next_type_reg  <= TYPE_MIN;
            used_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                share_mode_reg <= cfg_wr_data;
            end

            rd_vld_reg <= issue;
            if (cmd.op == OP_DISPATCH) begin
                scan_cnt_reg <= '0;
            end else if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end

            // Sharing off: a get draws straight from the counter.
            if ((cmd.op == OP_DISPATCH) && (req_kind_reg == KIND_GET)
                    && !share_mode_reg && !exhausted) begin
                next_type_reg <= next_type_reg + COUNT_W'(1);
            end
            if ((cmd.op == OP_DRAW) && !exhausted) begin
                next_type_reg <= next_type_reg + COUNT_W'(1);
            end

            if ((cmd.op == OP_CLEAR) && hit) begin
                used_reg[rd_idx_reg] <= 1'b0;
            end
            if (wr_en) begin
                used_reg[wr_idx] <= 1'b1;
            end

            if ((cmd.op == OP_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_kind_reg    <= s_tuser;
            req_key_reg     <= s_tdata[KW-1:0];
            req_present_reg <= s_tdata[16];
            req_tnum_reg    <= s_tdata[23:17];
        end

        rd_idx_reg <= scan_idx;
        if (issue) begin
            rd_key_reg <= key_mem[scan_idx];
        end
        if (wr_en) begin
            key_mem[wr_idx] <= req_key_reg;
        end

        unique case (cmd.op)
            OP_DISPATCH: begin
                if (share_mode_reg && !req_present_reg) begin
                    res_pt_reg     <= '0;
                    res_status_reg <= ST_NO_CODEC;
                end else if (req_kind_reg == KIND_REGISTER) begin
                    res_pt_reg     <= req_tnum_reg;
                    res_status_reg <= ST_OK;
                end else if (exhausted) begin
                    res_pt_reg     <= '0;
                    res_status_reg <= ST_EXHAUSTED;
                end else begin
                    res_pt_reg     <= next_type_reg[TYPE_W-1:0];
                    res_status_reg <= ST_OK;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    res_pt_reg     <= TYPE_MIN[TYPE_W-1:0] + TYPE_W'(rd_idx_reg);
                    res_status_reg <= ST_OK;
                end
            end
            OP_DRAW: begin
                if (exhausted) begin
                    res_pt_reg     <= '0;
                    res_status_reg <= ST_EXHAUSTED;
                end else if (draw_free) begin
                    res_pt_reg     <= next_type_reg[TYPE_W-1:0];
                    res_status_reg <= ST_OK;
                end
            end
            OP_BIND: begin
                res_pt_reg     <= req_tnum_reg;
                res_status_reg <= ST_OK;
            end
            OP_IDLE, OP_CLEAR, OP_FINISH: begin
            end
            default: begin
            end
        endcase

        if ((cmd.op == OP_FINISH) && out_free) begin
            out_pt_reg     <= res_pt_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_pt_reg};

endmodule

@@ sv/dynamic_payload_type_allocator.sv @@
// Sequence: accept, dispatch, optional table walk, then the result is registered out;
//   a shared get scans the SLOTS-entry key table and on a miss then steps the
//   type counter one type per cycle.
// Throughput: one item at a time; the next request is not taken until the result
//   has been handed to the output register.
// Reset: synchronous, active low; counter to 96, all slots free, sharing off.
// ----------------------------------------------------------------------------
// Dynamic payload type allocator
// Hands out dynamic payload types 96 to 127, optionally shared per codec key.
// ----------------------------------------------------------------------------
module dynamic_payload_type_allocator #(
    parameter int KEY_BITS = 16,
    parameter int SLOTS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // share_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // codec_key[15:0], codec_present[16], type_number[23:17]
    input  logic        s_tuser,      // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata       // payload_type[6:0], status[8:7], zero pad[15:9]
);
    import dpta_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    dpta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dpta_datapath #(
        .KEY_BITS (KEY_BITS),
        .SLOTS    (SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Dynamic payload type allocator testbench
// Streams get and register requests into the allocator and checks every
// grant against a cycle-free prediction of the type counter and slot table.
// Sharing is switched off, on, off, on and off again between drained phases,
// with random gaps on the request side and random stalls on the grant side,
// both off in the second sharing-off phase.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpta_pkg::*;

    localparam int SLOT_COUNT     = 32;
    localparam int POOL_SIZE      = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 30;

    typedef struct {
        logic        kind;
        logic [15:0] key;
        logic        present;
        logic [6:0]  tnum;
    } alloc_req_t;

    typedef struct {
        logic [6:0] ptype;
        status_t    status;
    } grant_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;  // codec_key[15:0], codec_present[16], type_number[23:17]
    logic        s_tuser     = 1'b0;  // kind
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;  // payload_type[6:0], status[8:7], zero pad[15:9]

    dynamic_payload_type_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Mirror of the allocator state.
    logic [7:0]  next_type_q = TYPE_MIN;
    logic        slot_taken [SLOT_COUNT];
    logic [15:0] slot_codec [SLOT_COUNT];
    logic        share_q     = 1'b0;

    alloc_req_t  pending_reqs[$];
    grant_t      expected_grants[$];
    alloc_req_t  in_hand;
    logic        holding     = 1'b0;
    int          send_gap    = 0;
    int          stall_left  = 0;
    bit          gaps_on     = 1'b1;
    int          errors      = 0;
    int          sent_count  = 0;
    int          grant_count = 0;
    int          exhausted_seen = 0;
    int          quiet_cycles = 0;
    logic [15:0] key_pool [POOL_SIZE];
    grant_t      want;
    logic [6:0]  got_type;
    logic [1:0]  got_status;

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int slot_for(input logic [7:0] t);
        if (t < TYPE_MIN || t > TYPE_MAX) return -1;
        if (int'(t - TYPE_MIN) >= SLOT_COUNT) return -1;
        return int'(t - TYPE_MIN);
    endfunction

    // The counter sticks one past the top once every dynamic type is gone.
    task automatic draw_type(output bit ok, output logic [7:0] t);
        t = next_type_q;
        if (next_type_q > TYPE_MAX) begin
            next_type_q = 8'(TYPE_MAX + 1);
            ok = 1'b0;
        end else begin
            ok = 1'b1;
            next_type_q = next_type_q + 8'd1;
        end
    endtask

    task automatic move_codec(input logic [7:0] t, input logic [15:0] k);
        int s;
        s = slot_for(t);
        if (s >= 0) slot_taken[s] = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_taken[i] && slot_codec[i] == k) slot_taken[i] = 1'b0;
        end
        if (s >= 0) begin
            slot_taken[s] = 1'b1;
            slot_codec[s] = k;
        end
    endtask

    task automatic predict_allocation(input alloc_req_t r);
        grant_t     g;
        logic [7:0] t;
        bit         ok;
        bit         hit;
        int         s;
        g.ptype  = '0;
        g.status = ST_OK;
        if (r.kind == KIND_GET) begin
            if (!share_q) begin
                draw_type(ok, t);
                if (ok) g.ptype = t[6:0];
                else g.status = ST_EXHAUSTED;
            end else if (!r.present) begin
                g.status = ST_NO_CODEC;
            end else begin
                hit = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!hit && slot_taken[i] && slot_codec[i] == r.key) begin
                        hit = 1'b1;
                        g.ptype = 7'(TYPE_MIN + i);
                    end
                end
                if (!hit) begin
                    // Walk the counter past types whose slot is already held.
                    do begin
                        draw_type(ok, t);
                        s = slot_for(t);
                    end while (ok && s >= 0 && slot_taken[s]);
                    if (ok) begin
                        move_codec(t, r.key);
                        g.ptype = t[6:0];
                    end else begin
                        g.status = ST_EXHAUSTED;
                    end
                end
            end
        end else begin
            if (!share_q) begin
                g.ptype = r.tnum;
            end else if (!r.present) begin
                g.status = ST_NO_CODEC;
            end else begin
                move_codec({1'b0, r.tnum}, r.key);
                g.ptype = r.tnum;
            end
        end
        expected_grants.push_back(g);
    endtask

    task automatic push_req(input logic kind, input logic [15:0] key,
                            input logic present, input logic [6:0] tnum);
        alloc_req_t r;
        r.kind    = kind;
        r.key     = key;
        r.present = present;
        r.tnum    = tnum;
        pending_reqs.push_back(r);
    endtask

    function automatic alloc_req_t random_req(input int get_pct);
        alloc_req_t r;
        int pick;
        r.kind = ($urandom_range(0, 99) < get_pct) ? KIND_GET : KIND_REGISTER;
        pick = $urandom_range(0, 99);
        r.key = (pick < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : 16'($urandom);
        r.present = ($urandom_range(0, 99) < 90);
        pick = $urandom_range(0, 99);
        if (pick < 70) r.tnum = 7'($urandom_range(96, 127));
        else r.tnum = 7'($urandom_range(0, 127));
        return r;
    endfunction

    task automatic push_random(input int count, input int get_pct);
        repeat (count) pending_reqs.push_back(random_req(get_pct));
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || holding || expected_grants.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_sharing(input logic v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        share_q = v;
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_allocation(in_hand);
                holding = 1'b0;
                sent_count++;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_hand = pending_reqs.pop_front();
                    holding = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_hand.tnum, in_hand.present, in_hand.key};
                    s_tuser  <= in_hand.kind;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Grant monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_type   = m_tdata[6:0];
                got_status = m_tdata[8:7];
                grant_count++;
                if (got_status == ST_EXHAUSTED) exhausted_seen++;
                if (expected_grants.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected grant, expected none, actual type %0d status %0d",
                                 $time, got_type, got_status);
                end else begin
                    want = expected_grants.pop_front();
                    if (want.ptype !== got_type || want.status !== got_status) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: grant mismatch, expected type %0d status %0d, actual type %0d status %0d",
                                     $time, want.ptype, want.status, got_type, got_status);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_taken[i] = 1'b0;
            slot_codec[i] = '0;
        end
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Sharing off after reset: plain counter, codec flag ignored.
        push_req(KIND_GET, 16'h0000, 1'b0, 7'd0);
        push_req(KIND_GET, 16'hFFFF, 1'b1, 7'd127);
        push_req(KIND_REGISTER, 16'h1234, 1'b0, 7'd127);
        push_req(KIND_REGISTER, 16'hFFFF, 1'b1, 7'd0);
        wait_drained();

        set_sharing(1'b1);
        push_req(KIND_GET, 16'h0001, 1'b0, 7'd0);
        push_req(KIND_REGISTER, 16'h0001, 1'b0, 7'd100);
        push_req(KIND_REGISTER, 16'h0001, 1'b1, 7'd100);
        push_req(KIND_REGISTER, 16'h0002, 1'b1, 7'd98);
        push_req(KIND_REGISTER, 16'h0003, 1'b1, 7'd99);
        push_req(KIND_GET, 16'h0001, 1'b1, 7'd0);
        // A miss here has to skip the three held types at the counter.
        push_req(KIND_GET, 16'h0004, 1'b1, 7'd0);
        push_req(KIND_REGISTER, 16'h0001, 1'b1, 7'd127);
        push_req(KIND_GET, 16'h0001, 1'b1, 7'd0);
        // Below the dynamic range the codec is only unbound.
        push_req(KIND_REGISTER, 16'h0002, 1'b1, 7'd50);
        push_req(KIND_GET, 16'h0002, 1'b1, 7'd0);
        push_req(KIND_REGISTER, 16'hFFFF, 1'b1, 7'd96);
        push_req(KIND_REGISTER, 16'h0000, 1'b1, 7'd96);
        push_req(KIND_GET, 16'hFFFF, 1'b1, 7'd0);
        push_req(KIND_GET, 16'h0000, 1'b1, 7'd0);
        push_req(KIND_REGISTER, 16'h0005, 1'b1, 7'd0);
        push_req(KIND_REGISTER, 16'h0005, 1'b1, 7'd95);
        push_req(KIND_REGISTER, 16'h0006, 1'b1, 7'd127);
        wait_drained();

        push_random(150, 45);
        wait_drained();

        // Counter is spent by now, so plain gets report exhaustion.
        set_sharing(1'b0);
        gaps_on = 1'b0;
        push_random(60, 50);
        wait_drained();

        set_sharing(1'b1);
        gaps_on = 1'b1;
        push_random(150, 55);
        wait_drained();

        set_sharing(1'b0);
        push_random(20, 50);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("Checked %0d grants for %0d requests across sharing off, on, off, on, off.",
                 grant_count, sent_count);
        $display("Exhausted answers: %0d; type counter ended at %0d.",
                 exhausted_seen, next_type_q);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
